@@ design/fbpl_pkg.sv @@
// ----------------------------------------------------------------------------
// fbpl_pkg
// Shared types and constants for the fixed block pool with data list.
// ----------------------------------------------------------------------------
`default_nettype none

package fbpl_pkg;

    localparam int POOL_ENTRIES = 16;
    localparam int ENTRY_BYTES  = 8;

    localparam int IDX_W  = $clog2(POOL_ENTRIES);
    localparam int LINK_W = $clog2(POOL_ENTRIES + 1);
    localparam int CNT_W  = $clog2(POOL_ENTRIES + 1);
    localparam int LEN_W  = 4;
    localparam int DATA_W = 64;
    localparam int EIDX_W = 4;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_ENTRIES);
    localparam logic [LEN_W-1:0]  MAX_LEN_RESET = LEN_W'(8);

    // Stream packing
    localparam int S_TDATA_W = 72;  // data_word, data_len, free_index
    localparam int S_TUSER_W = 2;   // req_type
    localparam int M_TDATA_W = 16;  // status, entry_index, free_count, list_empty

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_ALLOC  = 2'd2,
        REQ_FREE   = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LONG  = 2'd1,
        ST_POOL_EMPTY = 2'd2,
        ST_LIST_EMPTY = 2'd3
    } status_t;

    typedef struct packed {
        req_kind_t          req_type;
        logic [DATA_W-1:0]  data_word;
        logic [LEN_W-1:0]   data_len;
        logic [EIDX_W-1:0]  free_index;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [EIDX_W-1:0]  entry_index;
        logic [CNT_W-1:0]   free_count;
        logic               list_empty;
    } rsp_t;

    typedef struct packed {
        logic                   en;
        logic [IDX_W-1:0]       idx;
        logic [ENTRY_BYTES-1:0] byte_en;
        logic [DATA_W-1:0]      data;
    } data_wr_t;

endpackage

`default_nettype wire

@@ design/fbpl_data.sv @@
// ----------------------------------------------------------------------------
// fbpl_data
// Entry payload store with per-byte write enables.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpl_data import fbpl_pkg::*; (
    input  wire logic     aclk,
    input  wire data_wr_t data_wr
);

    logic [DATA_W-1:0] entry_mem [POOL_ENTRIES];

    // Write only the enabled bytes; the rest keep their old contents
    always_ff @(posedge aclk) begin
        if (data_wr.en) begin
            for (int k = 0; k < ENTRY_BYTES; k++) begin
                if (data_wr.byte_en[k]) begin
                    entry_mem[data_wr.idx][k*8 +: 8] <= data_wr.data[k*8 +: 8];
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ design/fbpl_link.sv @@
// ----------------------------------------------------------------------------
// fbpl_link
// Link store, chain heads and free count; resolves one request per cycle while fire is high.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpl_link import fbpl_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             fire,
    input  wire req_t             req,
    input  wire logic [LEN_W-1:0] max_len,
    output rsp_t                  rsp,
    output data_wr_t              data_wr
);

    logic [LINK_W-1:0] link_reg [POOL_ENTRIES];
    logic [LINK_W-1:0] list_head_reg, list_head_next;
    logic [LINK_W-1:0] free_head_reg, free_head_next;
    logic [CNT_W-1:0]  free_total_reg, free_total_next;

    logic [IDX_W-1:0]  node_idx;
    logic [LINK_W-1:0] link_rd;
    logic [LINK_W-1:0] next_link;
    logic [LINK_W-1:0] free_in;
    logic              free_ok;
    logic              list_ok;
    logic              len_bad;
    logic              link_wr_en;
    logic [IDX_W-1:0]  link_wr_idx;
    logic [LINK_W-1:0] link_wr_val;
    logic              cnt_up;
    logic              cnt_dn;
    logic [ENTRY_BYTES-1:0] byte_en;

    always_comb begin
        node_idx  = (req.req_type == REQ_DELETE) ? list_head_reg[IDX_W-1:0]
                                                 : free_head_reg[IDX_W-1:0];
        link_rd   = link_reg[node_idx];
        next_link = (link_rd < NULL_LINK) ? link_rd : NULL_LINK;
        free_in   = LINK_W'(req.free_index);
        free_ok   = free_head_reg < NULL_LINK;
        list_ok   = list_head_reg < NULL_LINK;
        len_bad   = (req.data_len > max_len) || (req.data_len > LEN_W'(ENTRY_BYTES));
        for (int k = 0; k < ENTRY_BYTES; k++) begin
            byte_en[k] = LEN_W'(k) < req.data_len;
        end

        list_head_next = list_head_reg;
        free_head_next = free_head_reg;
        link_wr_en     = 1'b0;
        link_wr_idx    = node_idx;
        link_wr_val    = list_head_reg;
        cnt_up         = 1'b0;
        cnt_dn         = 1'b0;
        rsp.status      = ST_OK;
        rsp.entry_index = '0;
        data_wr.en      = 1'b0;
        data_wr.idx     = node_idx;
        data_wr.byte_en = byte_en;
        data_wr.data    = req.data_word;

        unique case (req.req_type)
            REQ_INSERT: begin
                if (len_bad) begin
                    rsp.status = ST_TOO_LONG;
                end else if (!free_ok) begin
                    rsp.status = ST_POOL_EMPTY;
                end else begin
                    free_head_next  = next_link;
                    link_wr_en      = 1'b1;
                    link_wr_val     = list_head_reg;
                    list_head_next  = LINK_W'(node_idx);
                    cnt_dn          = 1'b1;
                    data_wr.en      = fire;
                    rsp.entry_index = EIDX_W'(node_idx);
                end
            end
            REQ_DELETE: begin
                if (!list_ok) begin
                    rsp.status = ST_LIST_EMPTY;
                end else begin
                    list_head_next  = next_link;
                    link_wr_en      = 1'b1;
                    link_wr_val     = free_head_reg;
                    free_head_next  = LINK_W'(node_idx);
                    cnt_up          = 1'b1;
                    rsp.entry_index = EIDX_W'(node_idx);
                end
            end
            REQ_ALLOC: begin
                if (!free_ok) begin
                    rsp.status = ST_POOL_EMPTY;
                end else begin
                    free_head_next  = next_link;
                    cnt_dn          = 1'b1;
                    rsp.entry_index = EIDX_W'(node_idx);
                end
            end
            REQ_FREE: begin
                // Out-of-range index is ignored; no double-free check
                if (free_in < NULL_LINK) begin
                    link_wr_en     = 1'b1;
                    link_wr_idx    = free_in[IDX_W-1:0];
                    link_wr_val    = free_head_reg;
                    free_head_next = free_in;
                    cnt_up         = 1'b1;
                end
            end
            default: ;
        endcase

        free_total_next = free_total_reg;
        if (cnt_up && (free_total_reg < CNT_W'(POOL_ENTRIES))) begin
            free_total_next = free_total_reg + 1'b1;
        end else if (cnt_dn && (free_total_reg != '0)) begin
            free_total_next = free_total_reg - 1'b1;
        end

        rsp.free_count = free_total_next;
        rsp.list_empty = !(list_head_next < NULL_LINK);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < POOL_ENTRIES; i++) begin
                link_reg[i] <= LINK_W'(i + 1);
            end
            list_head_reg  <= NULL_LINK;
            free_head_reg  <= '0;
            free_total_reg <= CNT_W'(POOL_ENTRIES);
        end else if (fire) begin
            if (link_wr_en) begin
                link_reg[link_wr_idx] <= link_wr_val;
            end
            list_head_reg  <= list_head_next;
            free_head_reg  <= free_head_next;
            free_total_reg <= free_total_next;
        end
    end

endmodule

`default_nettype wire

@@ design/fixed_block_pool_with_list_core.sv @@
// ----------------------------------------------------------------------------
// fixed_block_pool_with_list_core
// Fixed pool of 16 entries shared by a free chain and a singly linked list.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ stream: the request kind on s_tuser, the payload
//   word, payload length and free index on s_tdata. Each request produces
//   exactly one result transaction on the m_ stream carrying status, entry
//   index, free count and the list-empty flag.
//   A request is captured into an input register, resolved against the link
//   store and chain heads in combinational logic, and lands in the output
//   register, which drives m_tvalid and m_tdata.
//   Throughput is one transaction per cycle while the receiver keeps m_tready
//   high; the bound is the link register file, which is read at the chain
//   head and written back in the same cycle.
//   If the receiver stalls, the result holds in the output register and one
//   more request waits in the input register; s_tready then drops until the
//   result is taken.
//   cfg_wr_en/cfg_wr_data set max_data_len; write it only while idle.
//   Reset (aresetn low, synchronous) rebuilds the free chain 0..15, empties
//   the list, sets the free count to 16 and max_data_len to 8. Entry payload
//   contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_block_pool_with_list_core import fbpl_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [63:0] data_word, [67:64] data_len, [71:68] free_index
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] req_type
    input  wire logic [S_TUSER_W-1:0] s_tuser,

    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [1:0] status, [5:2] entry_index, [10:6] free_count, [11] list_empty,
    // [15:12] zero
    output logic [M_TDATA_W-1:0]      m_tdata,

    input  wire logic                 cfg_wr_en,
    input  wire logic [LEN_W-1:0]     cfg_wr_data
);

    logic             in_vld_reg;
    req_t             req_reg;
    logic             out_vld_reg;
    rsp_t             rsp_reg;
    logic [LEN_W-1:0] max_len_reg;

    logic     fire;
    rsp_t     rsp;
    data_wr_t data_wr;

    // Advance the held request whenever the output register is free or drains
    assign fire     = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            max_len_reg <= MAX_LEN_RESET;
        end else begin
            if (cfg_wr_en) begin
                max_len_reg <= cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                in_vld_reg <= 1'b1;
            end else if (fire) begin
                in_vld_reg <= 1'b0;
            end
            if (fire) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers: capture on accept, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_reg.req_type   <= req_kind_t'(s_tuser[1:0]);
            req_reg.data_word  <= s_tdata[DATA_W-1:0];
            req_reg.data_len   <= s_tdata[DATA_W +: LEN_W];
            req_reg.free_index <= s_tdata[DATA_W+LEN_W +: EIDX_W];
        end
        if (fire) begin
            rsp_reg <= rsp;
        end
    end

    fbpl_link u_link (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .req     (req_reg),
        .max_len (max_len_reg),
        .rsp     (rsp),
        .data_wr (data_wr)
    );

    fbpl_data u_data (
        .aclk    (aclk),
        .data_wr (data_wr)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {4'b0000, rsp_reg.list_empty, rsp_reg.free_count,
                       rsp_reg.entry_index, rsp_reg.status};

endmodule

`default_nettype wire

@@ design/fbpl_chk.sv @@
// ----------------------------------------------------------------------------
// fbpl_chk
// Port-level checks for the block pool core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpl_chk import fbpl_pkg::*; (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Free count never exceeds the pool size
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[10:6] <= CNT_W'(POOL_ENTRIES))
        else $error("free count out of range");

    // Failed requests report entry zero
    a_fail_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != ST_OK) |-> m_tdata[5:2] == '0)
        else $error("failed request reports an entry");

    // A list-empty failure leaves the list empty
    a_list_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == ST_LIST_EMPTY) |-> m_tdata[11])
        else $error("list-empty status with non-empty list");

endmodule

bind fixed_block_pool_with_list_core fbpl_chk u_fbpl_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
